// ----- rtl/lcg48_pkg.sv -----
// ----------------------------------------------------------------------------
// lcg48_pkg
// Shared types and constants of the 48-bit linear congruential generator.
// ----------------------------------------------------------------------------
package lcg48_pkg;

    localparam int STATE_W = 48;
    localparam int WORD_W  = 32;
    localparam int BOUND_W = 31;
    localparam int MULT_W  = 35;
    localparam int LIMB_W  = 16;
    localparam int PROD_W  = WORD_W + BOUND_W;

    localparam logic [MULT_W-1:0]  LCG_MULT   = 35'h5_DEEC_E66D;
    localparam logic [STATE_W-1:0] LCG_ADD    = 48'd11;
    localparam logic [STATE_W-1:0] SEED_RESET = 48'd1;
    localparam int RAW_LSB  = 16;
    localparam int BOOL_BIT = 30;

    localparam logic [1:0] LIMB_FIRST = 2'd0;
    localparam logic [1:0] LIMB_MID   = 2'd1;
    localparam logic [1:0] LIMB_LAST  = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_RAW     = 2'd0,
        OP_BOUNDED = 2'd1,
        OP_RANGED  = 2'd2,
        OP_BOOL    = 2'd3
    } op_t;

    // classified request travelling from front to back
    typedef struct packed {
        op_t                opcode;
        logic               bad;
        logic [BOUND_W-1:0] bound;
        logic [WORD_W-1:0]  offset;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_SCALE,
        BK_DONE
    } back_state_t;

endpackage

// ----- rtl/lcg48_front.sv -----
// ----------------------------------------------------------------------------
// lcg48_front
// Accepts requests, checks the bound or range width, and queues the job.
// ----------------------------------------------------------------------------
module lcg48_front
    import lcg48_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] low_bound,
    input  logic signed [31:0] high_bound,
    output logic               job_valid,
    input  logic               job_take,
    output job_t               job
);

    job_t               job_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               accept;
    logic               take;
    logic signed [32:0] range_width;
    job_t               new_job;

    // exact range width, no wrap
    assign range_width = 33'(high_bound) - 33'(low_bound);

    always_comb
    begin
        new_job.opcode = op_t'(opcode);
        new_job.bad    = 1'b0;
        new_job.bound  = high_bound[BOUND_W-1:0];
        new_job.offset = '0;
        case (op_t'(opcode))
            OP_BOUNDED:
            begin
                new_job.bad = high_bound[31] || (high_bound == 32'sd0);
            end
            OP_RANGED:
            begin
                new_job.bound  = range_width[BOUND_W-1:0];
                new_job.offset = low_bound;
                new_job.bad    = range_width[32] || range_width[31]
                                 || (range_width == 33'sd0);
            end
            default:
            begin
                new_job.bad = 1'b0;
            end
        endcase
    end

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = job_q[rd_ptr_reg];
    assign accept    = push && !full;
    assign take      = job_take && job_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (accept && !take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take && !accept)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_q[wr_ptr_reg] <= new_job;
        end
    end

endmodule

// ----- rtl/lcg48_back.sv -----
// ----------------------------------------------------------------------------
// lcg48_back
// Advances the generator state limb by limb, scales the raw word and holds
// the result item until it is popped.
// ----------------------------------------------------------------------------
module lcg48_back
    import lcg48_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                seed_write,
    input  logic [STATE_W-1:0]  seed_value,
    input  logic                job_valid,
    output logic                job_take,
    input  job_t                job,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  random_value,
    output logic                bad_bound
);

    back_state_t           state_reg, state_next;
    logic [STATE_W-1:0]    gen_reg, gen_next;
    logic [STATE_W-1:0]    acc_reg, acc_next;
    logic [1:0]            limb_reg, limb_next;
    job_t                  job_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]     value_reg;
    logic                  bad_reg;

    logic [LIMB_W-1:0]     limb;
    logic [LIMB_W+MULT_W-1:0] pp;
    logic [STATE_W-1:0]    pp_shifted;
    logic [STATE_W-1:0]    acc_sum;
    logic [WORD_W-1:0]     raw;
    logic                  slot_free;
    logic                  job_load;
    logic                  out_load;
    logic [WORD_W-1:0]     value_next;

    assign raw       = gen_reg[RAW_LSB +: WORD_W];
    assign slot_free = !out_valid_reg || pop;

    // one 16-bit limb of the state times the multiplier per cycle
    always_comb
    begin
        case (limb_reg)
            LIMB_FIRST: limb = gen_reg[LIMB_W-1:0];
            LIMB_MID:   limb = gen_reg[2*LIMB_W-1:LIMB_W];
            default:    limb = gen_reg[3*LIMB_W-1:2*LIMB_W];
        endcase
        pp = (LIMB_W+MULT_W)'(limb) * (LIMB_W+MULT_W)'(LCG_MULT);
        case (limb_reg)
            LIMB_FIRST: pp_shifted = pp[STATE_W-1:0];
            LIMB_MID:   pp_shifted = {pp[STATE_W-LIMB_W-1:0], {LIMB_W{1'b0}}};
            default:    pp_shifted = {pp[STATE_W-2*LIMB_W-1:0], {2*LIMB_W{1'b0}}};
        endcase
        acc_sum = acc_reg + pp_shifted;
    end

    always_comb
    begin
        case (job_reg.opcode)
            OP_RAW:  value_next = raw;
            OP_BOOL: value_next = {{(WORD_W-1){1'b0}}, raw[BOOL_BIT]};
            default: value_next = job_reg.bad ? '0
                                  : job_reg.offset + {1'b0, prod_reg[PROD_W-1:WORD_W]};
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                if (limb_reg == LIMB_LAST)
                begin
                    state_next = BK_SCALE;
                end
            end
            BK_SCALE:
            begin
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        job_take  = 1'b0;
        job_load  = 1'b0;
        out_load  = 1'b0;
        gen_next  = gen_reg;
        acc_next  = acc_reg;
        limb_next = limb_reg;
        case (state_reg)
            BK_IDLE:
            begin
                job_take  = job_valid;
                job_load  = job_valid;
                acc_next  = '0;
                limb_next = LIMB_FIRST;
            end
            BK_MUL:
            begin
                acc_next  = acc_sum;
                limb_next = limb_reg + 1'b1;
                if (limb_reg == LIMB_LAST)
                begin
                    gen_next = acc_sum + LCG_ADD;
                end
            end
            BK_DONE:
            begin
                out_load = slot_free;
            end
            default:
            begin
                job_take = 1'b0;
            end
        endcase
        if (seed_write)
        begin
            gen_next = seed_value;
        end
        out_valid_next = (out_valid_reg && !pop) || out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            gen_reg       <= SEED_RESET;
            limb_reg      <= LIMB_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            limb_reg      <= limb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (job_load)
        begin
            job_reg <= job;
        end
        if (state_reg == BK_SCALE)
        begin
            prod_reg <= PROD_W'(raw) * PROD_W'(job_reg.bound);
        end
        if (out_load)
        begin
            value_reg <= value_next;
            bad_reg   <= job_reg.bad;
        end
    end

    assign empty        = !out_valid_reg;
    assign random_value = value_reg;
    assign bad_bound    = bad_reg;

endmodule

// ----- rtl/lcg48_random_generator.sv -----
// ----------------------------------------------------------------------------
// lcg48_random_generator
// 48-bit linear congruential random number generator with queue interfaces.
// ----------------------------------------------------------------------------
// Each request advances the 48-bit state (x * 0x5DEECE66D + 11) and returns
// the raw word (state bits 47..16), a bounded value, a ranged value or a
// boolean; a bound or range width outside 1..2^31-1 gives 0 with bad_bound
// set, and the state still advances. Writing seed_value reloads the state
// (reset value 1); do so only while no request is in flight. On its way from
// its push to the output ports a request is taken from the queue by the back
// end, the state multiply is done one 16-bit limb per cycle over three limbs,
// the 32x31 scaling multiply follows and the result is registered. The back
// end handles one item at a time, so it takes no new request until the last
// result is registered, and it waits while an unpopped result holds the
// output. A two-item queue after the front end lets requests be pushed while
// a result waits.
// ----------------------------------------------------------------------------
module lcg48_random_generator
    import lcg48_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                seed_write,
    input  logic [47:0]         seed_value,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          opcode,
    input  logic signed [31:0]  low_bound,
    input  logic signed [31:0]  high_bound,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  random_value,
    output logic                bad_bound
);

    logic job_valid;
    logic job_take;
    job_t job;

    lcg48_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .low_bound  (low_bound),
        .high_bound (high_bound),
        .job_valid  (job_valid),
        .job_take   (job_take),
        .job        (job)
    );

    lcg48_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_write   (seed_write),
        .seed_value   (seed_value),
        .job_valid    (job_valid),
        .job_take     (job_take),
        .job          (job),
        .empty        (empty),
        .pop          (pop),
        .random_value (random_value),
        .bad_bound    (bad_bound)
    );

endmodule

// ----- rtl/lcg48_checker.sv -----
// ----------------------------------------------------------------------------
// lcg48_checker
// Port-level checks on the generator's queue interfaces.
// ----------------------------------------------------------------------------
module lcg48_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [31:0] random_value,
    input  logic               bad_bound
);

    // a waiting result item holds until popped
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(random_value) && $stable(bad_bound)))
        else $error("result item changed while waiting");

    // a rejected bound always reads as zero
    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && bad_bound) |-> (random_value == 32'sd0))
        else $error("bad bound with non-zero value");

    // the queue fills only through an accepted push
    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

    // a result cannot appear the cycle after a push into an idle block
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !full && push && $past(empty) && $past(!full) && $past(!push)
         && $past(empty, 2) && $past(!push, 2) && $past(empty, 3)
         && $past(!push, 3) && $past(empty, 4) && $past(!push, 4)
         && $past(empty, 5) && $past(!push, 5) && $past(empty, 6)
         && $past(!push, 6)) |=> empty)
        else $error("result appeared too early");

endmodule

bind lcg48_random_generator lcg48_checker u_lcg48_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .random_value (random_value),
    .bad_bound    (bad_bound)
);
